// ----- hdl/trc_pkg.sv -----
// ----------------------------------------------------------------------------
// trc_pkg: shared types, constants and lookup functions for the rotor cipher
// Holds the rotor wirings as letter-code tables, their inverses and the
// modulo-26 helpers used by the single-pass cipher datapath.
// ----------------------------------------------------------------------------
package trc_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CODE_W   = 5;
    localparam int unsigned TAB_SIZE = 32;

    localparam logic [CODE_W-1:0] LETTER_COUNT = 5'd26;
    localparam logic [CODE_W-1:0] LAST_CODE    = 5'd25;
    localparam logic [CHAR_W-1:0] ASCII_A      = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_Z      = 8'h5A;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [TAB_SIZE-1:0][CODE_W-1:0] t_table;

    // Turns a 26-letter wiring string into a table of letter codes.
    // Entries past the last letter are never addressed and read as zero.
    function automatic t_table f_wire(input logic [8*26-1:0] s);
        t_table      t;
        logic [7:0]  ch;
        t = '0;
        for (int i = 0; i < 26; i++) begin
            ch   = s[8*(25-i) +: 8];
            t[i] = CODE_W'(ch - ASCII_A);
        end
        return t;
    endfunction

    // Builds the reverse wiring: the index that holds each code.
    function automatic t_table f_invert(input t_table w);
        t_table t;
        t = '0;
        for (int i = 0; i < 26; i++) begin
            t[w[i]] = CODE_W'(i);
        end
        return t;
    endfunction

    localparam t_table WIRE_PLUG   = f_wire("AJDKSIRUXBLHWTMCQGZNPYFVOE");
    localparam t_table WIRE_RIGHT  = f_wire("BDFHJLCPRTXVZNYEIWGAKMUSQO");
    localparam t_table WIRE_MIDDLE = f_wire("AJDKSIRUXBLHWTMCQGZNPYFVOE");
    localparam t_table WIRE_LEFT   = f_wire("EKMFLGDQVZNTOWYHXUSPAIBRCJ");

    localparam t_table INV_PLUG    = f_invert(WIRE_PLUG);
    localparam t_table INV_RIGHT   = f_invert(WIRE_RIGHT);
    localparam t_table INV_MIDDLE  = f_invert(WIRE_MIDDLE);
    localparam t_table INV_LEFT    = f_invert(WIRE_LEFT);

    // (a + b) mod 26 for codes below 26.
    function automatic t_code f_add26(input t_code a, input t_code b);
        logic [CODE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, LETTER_COUNT}) begin
            s = s - {1'b0, LETTER_COUNT};
        end
        return s[CODE_W-1:0];
    endfunction

    // (a - b) mod 26 for codes below 26.
    function automatic t_code f_sub26(input t_code a, input t_code b);
        t_code d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + (LETTER_COUNT - b);
        end
        return d;
    endfunction

    // Position step with wrap from the last letter back to zero.
    function automatic t_code f_inc26(input t_code p);
        return (p == LAST_CODE) ? '0 : t_code'(p + 5'd1);
    endfunction

    function automatic t_code f_fwd(input t_table w, input t_code c, input t_code p);
        return w[f_add26(c, p)];
    endfunction

    function automatic t_code f_rev(input t_table inv, input t_code c, input t_code p);
        return f_sub26(inv[c], p);
    endfunction

endpackage

// ----- hdl/three_rotor_cipher_stream_top.sv -----
// ----------------------------------------------------------------------------
// three_rotor_cipher_stream_top: streaming three-rotor letter cipher
// Enciphers uppercase ASCII letters through plugboard, three rotors and a
// mirror reflector; every other byte passes through unchanged.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel (i_s_axis_*) takes one byte per transaction and the
// master channel (o_m_axis_*) returns exactly one byte per transaction, in
// order. tdata on both sides is the 8-bit character.
// Each accepted byte is captured in an input register together with the rotor
// positions that apply to it; the positions then step like an odometer
// (right, then middle, then left, each wrapping 25 -> 0 with no notches).
// The whole cipher path (plugboard, three forward rotors, reflector, three
// reverse rotors, inverse plugboard) is table lookups and modulo-26 adds that
// sit between the input register and the output register.
// o_m_axis_tvalid is the valid bit of the output register, which loads the byte
// from the input register whenever it is empty or its own byte is being taken.
// Throughput is one byte per cycle while the receiver does not stall: the input
// register refills in the same cycle that the output register is loaded or taken.
// When the receiver stalls, the output register holds its byte, the input
// register keeps a second byte, and only then does o_s_axis_tready drop.
// Synchronous active-low reset empties both registers and returns all three
// rotor positions to zero.
// ----------------------------------------------------------------------------
module three_rotor_cipher_stream_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [trc_pkg::CHAR_W-1:0]    i_s_axis_tdata,   // [7:0] char_in
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [trc_pkg::CHAR_W-1:0]    o_m_axis_tdata    // [7:0] char_out
);
    import trc_pkg::*;

    // Current rotor positions, applied to the next accepted byte.
    t_code r_pos_right, r_pos_middle, r_pos_left;
    t_code n_pos_right, n_pos_middle, n_pos_left;

    // Input register: the byte and the positions in force when it arrived.
    logic               r_s1_valid;
    logic [CHAR_W-1:0]  r_s1_char;
    t_code              r_s1_right, r_s1_middle, r_s1_left;

    // Output register.
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;

    logic               s_accept;
    logic               out_free;
    logic               s1_move;
    logic [CHAR_W-1:0]  n_out_char;

    // The output register can load when empty or when its byte is taken now.
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_move         = r_s1_valid && out_free;
    assign o_s_axis_tready = !r_s1_valid || out_free;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;

    // Odometer step of the rotor positions.
    always_comb begin
        n_pos_right  = f_inc26(r_pos_right);
        n_pos_middle = r_pos_middle;
        n_pos_left   = r_pos_left;
        if (r_pos_right == LAST_CODE) begin
            n_pos_middle = f_inc26(r_pos_middle);
            if (r_pos_middle == LAST_CODE) begin
                n_pos_left = f_inc26(r_pos_left);
            end
        end
    end

    // Single-pass cipher path from the input register to the output register.
    always_comb begin
        t_code c;
        c          = t_code'(r_s1_char - ASCII_A);
        c          = f_fwd(WIRE_PLUG,   c, '0);
        c          = f_fwd(WIRE_RIGHT,  c, r_s1_right);
        c          = f_fwd(WIRE_MIDDLE, c, r_s1_middle);
        c          = f_fwd(WIRE_LEFT,   c, r_s1_left);
        c          = LAST_CODE - c;     // mirror reflector
        c          = f_rev(INV_LEFT,    c, r_s1_left);
        c          = f_rev(INV_MIDDLE,  c, r_s1_middle);
        c          = f_rev(INV_RIGHT,   c, r_s1_right);
        c          = f_rev(INV_PLUG,    c, '0);
        if (r_s1_char >= ASCII_A && r_s1_char <= ASCII_Z) begin
            n_out_char = ASCII_A + CHAR_W'(c);
        end else begin
            n_out_char = r_s1_char;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_right  <= '0;
            r_pos_middle <= '0;
            r_pos_left   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_accept) begin
                r_pos_right  <= n_pos_right;
                r_pos_middle <= n_pos_middle;
                r_pos_left   <= n_pos_left;
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_char   <= i_s_axis_tdata;
            r_s1_right  <= r_pos_right;
            r_s1_middle <= r_pos_middle;
            r_s1_left   <= r_pos_left;
        end
        if (s1_move) begin
            r_out_char <= n_out_char;
        end
    end

    // Positions stay inside the alphabet.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos_right < LETTER_COUNT && r_pos_middle < LETTER_COUNT &&
        r_pos_left < LETTER_COUNT)
        else $error("rotor position out of range");

    // Every accepted byte steps the right rotor once.
    a_right_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_pos_right == f_inc26($past(r_pos_right)))
        else $error("right rotor did not step on acceptance");

    // The middle rotor moves only on a carry out of the right rotor.
    a_middle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_accept || r_pos_right != LAST_CODE) |=> $stable(r_pos_middle))
        else $error("middle rotor moved without a carry");

    // With both registers full and the receiver stalled, no byte is taken.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

endmodule
